FILE: hdl/sat_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package sat_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int LIM_W = $clog2(TABLE_ENTRIES + 1);

  localparam int FUNC_W     = 3;
  localparam int ADDR_W     = 48;
  localparam int QID_W      = 16;
  localparam int ANS_W      = 5;
  localparam int CNT_W      = 5;
  localparam int ID_W       = 5;
  localparam int MAXC_W     = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  localparam logic [FUNC_W-1:0] FUNC_CLEAR     = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_AUTH      = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_ASSOC     = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_DISC      = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_FIND_ADDR = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_FIND_ID   = 3'd5;

  localparam logic [1:0] ST_DISC  = 2'd0;
  localparam logic [1:0] ST_AUTH  = 2'd1;
  localparam logic [1:0] ST_ASSOC = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_CLIENTS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALLOW_NEW   = 1'd1;

  // Search request walking down the row of entries
  typedef struct packed {
    logic              valid;
    logic [FUNC_W-1:0] func;
    logic [ADDR_W-1:0] addr;
    logic [QID_W-1:0]  qid;
    logic [LIM_W-1:0]  lim;
    logic              match_found;
    logic [IDX_W-1:0]  match_idx;
    logic [1:0]        match_state;
    logic [ID_W-1:0]   match_id;
    logic              free_found;
    logic [IDX_W-1:0]  free_idx;
  } pkt_t;

  typedef enum logic [2:0] {
    UPD_NONE,
    UPD_AUTH,
    UPD_AUTH_NEW,
    UPD_ASSOC,
    UPD_DISC,
    UPD_CLEAR
  } upd_op_e;

  typedef struct packed {
    upd_op_e           op;
    logic [IDX_W-1:0]  idx;
    logic [ADDR_W-1:0] addr;
  } upd_t;

  typedef struct packed {
    logic             success;
    logic [ANS_W-1:0] answer;
    logic [CNT_W-1:0] players;
  } res_t;

endpackage
`default_nettype wire

FILE: hdl/sat_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module sat_cell
  import sat_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [IDX_W-1:0] cell_idx_i,
  input  wire pkt_t             pkt_i,
  output pkt_t                  pkt_o,
  input  wire upd_t             upd_i
);

  logic [1:0]        state_q, state_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic [ID_W-1:0]   id_q, id_d;
  pkt_t              pkt_q, pkt_d;
  logic              in_range, active, key_hit;

  assign in_range = LIM_W'(cell_idx_i) < pkt_i.lim;
  assign active   = state_q != ST_DISC;
  assign key_hit  = (pkt_i.func == FUNC_FIND_ID) ? (QID_W'(id_q) == pkt_i.qid)
                                                 : (addr_q == pkt_i.addr);

  always_comb begin
    pkt_d = pkt_i;
    if (pkt_i.valid && in_range) begin
      if (active && key_hit && !pkt_i.match_found) begin
        pkt_d.match_found = 1'b1;
        pkt_d.match_idx   = cell_idx_i;
        pkt_d.match_state = state_q;
        pkt_d.match_id    = id_q;
      end
      if (!active && !pkt_i.free_found) begin
        pkt_d.free_found = 1'b1;
        pkt_d.free_idx   = cell_idx_i;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    addr_d  = addr_q;
    id_d    = id_q;
    if (upd_i.op == UPD_CLEAR) begin
      state_d = ST_DISC;
      addr_d  = '0;
      id_d    = '0;
    end else if (upd_i.idx == cell_idx_i) begin
      case (upd_i.op)
        UPD_AUTH: state_d = ST_AUTH;
        UPD_AUTH_NEW: begin
          state_d = ST_AUTH;
          addr_d  = upd_i.addr;
        end
        UPD_ASSOC: begin
          state_d = ST_ASSOC;
          id_d    = ID_W'(int'(cell_idx_i) + 1);
        end
        UPD_DISC: state_d = ST_DISC;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_DISC;
      addr_q  <= '0;
      id_q    <= '0;
      pkt_q   <= '0;
    end else begin
      state_q <= state_d;
      addr_q  <= addr_d;
      id_q    <= id_d;
      pkt_q   <= pkt_d;
    end
  end

  assign pkt_o = pkt_q;

endmodule
`default_nettype wire

FILE: hdl/sat_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module sat_ctrl
  import sat_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [FUNC_W-1:0]     func_i,
  input  wire logic [ADDR_W-1:0]     station_address_i,
  input  wire logic [QID_W-1:0]      query_id_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output res_t                       res_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output pkt_t                       pkt_o,
  input  wire pkt_t                  pkt_i,
  output upd_t                       upd_o
);

  logic [MAXC_W-1:0] max_clients_q;
  logic              allow_new_q;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              busy_q;
  logic              out_valid_q, skid_valid_q;
  res_t              out_q, skid_q, res_d;
  logic              accept, out_take, done;
  logic [LIM_W-1:0]  lim;

  assign accept   = in_valid_i && in_ready_o;
  assign out_take = out_valid_q && out_ready_i;
  assign done     = pkt_i.valid;

  assign in_ready_o  = !busy_q && !skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign res_o       = out_q;

  always_comb begin
    if (32'(max_clients_q) > TABLE_ENTRIES) begin
      lim = LIM_W'(TABLE_ENTRIES);
    end else begin
      lim = LIM_W'(max_clients_q);
    end
  end

  always_comb begin
    pkt_o       = '0;
    pkt_o.valid = accept;
    pkt_o.func  = func_i;
    pkt_o.addr  = station_address_i;
    pkt_o.qid   = query_id_i;
    pkt_o.lim   = lim;
  end

  // Decide the outcome once the request has passed every entry
  always_comb begin
    upd_o         = '0;
    upd_o.op      = UPD_NONE;
    upd_o.addr    = pkt_i.addr;
    upd_o.idx     = pkt_i.match_idx;
    res_d.success = 1'b0;
    res_d.answer  = '0;
    count_d       = count_q;
    if (done) begin
      case (pkt_i.func)
        FUNC_CLEAR: begin
          upd_o.op      = UPD_CLEAR;
          count_d       = '0;
          res_d.success = 1'b1;
        end
        FUNC_AUTH: begin
          if (pkt_i.match_found) begin
            upd_o.op      = UPD_AUTH;
            res_d.success = 1'b1;
            res_d.answer  = ANS_W'(pkt_i.match_idx);
          end else if (allow_new_q && pkt_i.free_found) begin
            upd_o.op      = UPD_AUTH_NEW;
            upd_o.idx     = pkt_i.free_idx;
            count_d       = count_q + CNT_W'(1);
            res_d.success = 1'b1;
            res_d.answer  = ANS_W'(pkt_i.free_idx);
          end
        end
        FUNC_ASSOC: begin
          if (pkt_i.match_found && pkt_i.match_state == ST_ASSOC) begin
            res_d.success = 1'b1;
            res_d.answer  = ANS_W'(pkt_i.match_id);
          end else if (pkt_i.match_found && pkt_i.match_state == ST_AUTH) begin
            upd_o.op      = UPD_ASSOC;
            res_d.success = 1'b1;
            res_d.answer  = ANS_W'(ID_W'(int'(pkt_i.match_idx) + 1));
          end
        end
        FUNC_DISC: begin
          if (pkt_i.match_found) begin
            upd_o.op      = UPD_DISC;
            res_d.success = 1'b1;
            if (count_q != '0) begin
              count_d = count_q - CNT_W'(1);
            end
          end
        end
        FUNC_FIND_ADDR, FUNC_FIND_ID: begin
          if (pkt_i.match_found) begin
            res_d.success = 1'b1;
            res_d.answer  = ANS_W'(pkt_i.match_idx);
          end
        end
        default: ;
      endcase
    end
    res_d.players = count_d + CNT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_clients_q <= MAXC_W'(15);
      allow_new_q   <= 1'b0;
      count_q       <= '0;
      busy_q        <= 1'b0;
      out_valid_q   <= 1'b0;
      skid_valid_q  <= 1'b0;
      out_q         <= '0;
      skid_q        <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MAX_CLIENTS: max_clients_q <= MAXC_W'(cfg_wdata_i);
          CFG_ALLOW_NEW:   allow_new_q   <= cfg_wdata_i[0];
          default: ;
        endcase
      end
      count_q <= count_d;
      if (accept) begin
        busy_q <= 1'b1;
      end else if (done) begin
        busy_q <= 1'b0;
      end
      if (done) begin
        // Park the result in the skid stage while the output still waits
        if (!out_valid_q || out_take) begin
          out_q       <= res_d;
          out_valid_q <= 1'b1;
        end else begin
          skid_q       <= res_d;
          skid_valid_q <= 1'b1;
        end
      end else if (!out_valid_q || out_take) begin
        out_valid_q  <= skid_valid_q;
        out_q        <= skid_q;
        skid_valid_q <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

FILE: hdl/station_association_table.sv
// Channel   | Handshake               | Payload
// ----------+-------------------------+----------------------------------------
// request   | in_valid_i / in_ready_o | func_i, station_address_i, query_id_i
// result    | out_valid_o/out_ready_i | success_o, answer_value_o, players_count_o
// config    | cfg_we_i (no wait)      | cfg_idx_i, cfg_wdata_i
//
// A request walks the row of TABLE_ENTRIES entry cells, one cell per cycle,
// and the table update lands in the cycle after it leaves the last cell,
// together with the result; the next request is taken only once the last one has
// left the last cell and the skid stage is empty.
// Reset empties the table; no clearing pass.
// A result not yet taken waits in a skid stage, so the next request can run.
`timescale 1ns / 1ps
`default_nettype none
module station_association_table
  import sat_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [FUNC_W-1:0]     func_i,
  input  wire logic [ADDR_W-1:0]     station_address_i,
  input  wire logic [QID_W-1:0]      query_id_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic                       success_o,
  output logic [ANS_W-1:0]           answer_value_o,
  output logic [CNT_W-1:0]           players_count_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  pkt_t pkt_chain [TABLE_ENTRIES+1];
  upd_t upd;
  res_t res;

  sat_ctrl u_ctrl (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .func_i            (func_i),
    .station_address_i (station_address_i),
    .query_id_i        (query_id_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .res_o             (res),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .pkt_o             (pkt_chain[0]),
    .pkt_i             (pkt_chain[TABLE_ENTRIES]),
    .upd_o             (upd)
  );

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    sat_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (IDX_W'(g)),
      .pkt_i      (pkt_chain[g]),
      .pkt_o      (pkt_chain[g+1]),
      .upd_i      (upd)
    );
  end

  assign success_o       = res.success;
  assign answer_value_o  = res.answer;
  assign players_count_o = res.players;

endmodule
`default_nettype wire

FILE: hdl/sat_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module sat_assert
  import sat_pkg::*;
(
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             in_valid_i,
  input wire logic             in_ready_o,
  input wire logic             out_valid_o,
  input wire logic             out_ready_i,
  input wire logic             success_o,
  input wire logic [ANS_W-1:0] answer_value_o,
  input wire logic [CNT_W-1:0] players_count_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped before it was taken");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second request taken during a scan");

  a_fail_no_answer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !success_o |-> answer_value_o == '0)
    else $error("failed request carries an answer");

  a_players_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> players_count_o != '0)
    else $error("players count out of range");

endmodule

bind station_association_table sat_assert u_sat_assert (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .success_o       (success_o),
  .answer_value_o  (answer_value_o),
  .players_count_o (players_count_o)
);
`default_nettype wire

FILE: verif/sat_checker.sv
`timescale 1ns / 1ps
module sat_checker
  import sat_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  req_valid_i,
  input  wire logic                  req_ready_i,
  input  wire logic [FUNC_W-1:0]     func_i,
  input  wire logic [ADDR_W-1:0]     station_address_i,
  input  wire logic [QID_W-1:0]      query_id_i,
  input  wire logic                  res_valid_i,
  input  wire logic                  res_ready_i,
  input  wire logic                  success_i,
  input  wire logic [ANS_W-1:0]      answer_value_i,
  input  wire logic [CNT_W-1:0]      players_count_i,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output int unsigned                mismatch_cnt_o,
  output int unsigned                pending_cnt_o,
  output int unsigned                checked_cnt_o,
  output int unsigned                granted_cnt_o
);

  logic [1:0]        slot_state [TABLE_ENTRIES];
  logic [ADDR_W-1:0] slot_addr  [TABLE_ENTRIES];
  logic [ID_W-1:0]   slot_id    [TABLE_ENTRIES];
  logic [CNT_W-1:0]  live_count;
  logic [MAXC_W-1:0] slot_limit;
  logic              allow_new;
  res_t              expected_results [$];

  function automatic int active_slots();
    return (slot_limit > TABLE_ENTRIES) ? TABLE_ENTRIES : int'(slot_limit);
  endfunction

  function automatic void clear_table();
    int i;
    for (i = 0; i < TABLE_ENTRIES; i++) begin
      slot_state[i] = ST_DISC;
      slot_addr[i]  = '0;
      slot_id[i]    = '0;
    end
    live_count = '0;
  endfunction

  // lowest live entry holding this address, -1 if none
  function automatic int locate_station(logic [ADDR_W-1:0] a);
    int i;
    int hit;
    hit = -1;
    for (i = 0; i < active_slots(); i++)
      if (hit < 0 && slot_state[i] != ST_DISC && slot_addr[i] == a) hit = i;
    return hit;
  endfunction

  function automatic res_t apply_request(logic [FUNC_W-1:0] f, logic [ADDR_W-1:0] a,
                                         logic [QID_W-1:0] q);
    res_t r;
    int   hit;
    int   i;
    r   = '0;
    hit = -1;
    case (f)
      FUNC_CLEAR: begin
        clear_table();
        r.success = 1'b1;
      end
      FUNC_AUTH: begin
        hit = locate_station(a);
        if (hit >= 0) begin
          slot_state[hit] = ST_AUTH;
          r.success = 1'b1;
          r.answer  = hit[ANS_W-1:0];
        end else if (allow_new) begin
          // take the lowest free entry; its old id stays
          for (i = 0; i < active_slots(); i++) begin
            if (!r.success && slot_state[i] == ST_DISC) begin
              slot_state[i] = ST_AUTH;
              slot_addr[i]  = a;
              live_count    = live_count + 1'b1;
              r.success     = 1'b1;
              r.answer      = i[ANS_W-1:0];
            end
          end
        end
      end
      FUNC_ASSOC: begin
        hit = locate_station(a);
        if (hit >= 0) begin
          if (slot_state[hit] == ST_ASSOC) begin
            r.success = 1'b1;
            r.answer  = slot_id[hit];
          end else if (slot_state[hit] == ST_AUTH) begin
            slot_id[hit]    = hit[ID_W-1:0] + 1'b1;
            slot_state[hit] = ST_ASSOC;
            r.success = 1'b1;
            r.answer  = slot_id[hit];
          end
        end
      end
      FUNC_DISC: begin
        hit = locate_station(a);
        if (hit >= 0) begin
          slot_state[hit] = ST_DISC;
          if (live_count != 0) live_count = live_count - 1'b1;
          r.success = 1'b1;
        end
      end
      FUNC_FIND_ADDR: begin
        hit = locate_station(a);
        if (hit >= 0) begin
          r.success = 1'b1;
          r.answer  = hit[ANS_W-1:0];
        end
      end
      FUNC_FIND_ID: begin
        // authenticated entries match on their stale id as well
        for (i = 0; i < active_slots(); i++)
          if (hit < 0 && slot_state[i] != ST_DISC && {11'b0, slot_id[i]} == q) hit = i;
        if (hit >= 0) begin
          r.success = 1'b1;
          r.answer  = hit[ANS_W-1:0];
        end
      end
      default: ;
    endcase
    r.players = live_count + 1'b1;
    return r;
  endfunction

  task automatic report(input string msg);
    // keep the log short if the block goes badly wrong
    if (mismatch_cnt_o < 50) $display("%0t sat_checker: %s", $time, msg);
    mismatch_cnt_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    res_t want;
    if (!rst_ni) begin
      clear_table();
      slot_limit = MAXC_W'(15);
      allow_new  = 1'b0;
      expected_results.delete();
      mismatch_cnt_o = 0;
      pending_cnt_o  = 0;
      checked_cnt_o  = 0;
      granted_cnt_o  = 0;
    end else begin
      // compare before queuing: a result never belongs to a request of this edge
      if (res_valid_i && res_ready_i) begin
        if (expected_results.size() == 0) begin
          report($sformatf("result with no request waiting (success %0d answer %0d)",
                           success_i, answer_value_i));
        end else begin
          want = expected_results.pop_front();
          if (success_i !== want.success)
            report($sformatf("success got %0d want %0d", success_i, want.success));
          if (answer_value_i !== want.answer)
            report($sformatf("answer_value got %0d want %0d", answer_value_i, want.answer));
          if (players_count_i !== want.players)
            report($sformatf("players_count got %0d want %0d", players_count_i,
                             want.players));
          checked_cnt_o++;
          if (want.success) granted_cnt_o++;
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MAX_CLIENTS: slot_limit = cfg_wdata_i[MAXC_W-1:0];
          CFG_ALLOW_NEW:   allow_new  = cfg_wdata_i[0];
          default: ;
        endcase
      end
      if (req_valid_i && req_ready_i)
        expected_results.push_back(apply_request(func_i, station_address_i, query_id_i));
      pending_cnt_o = expected_results.size();
    end
  end

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
module tb_top
  import sat_pkg::*;
();

  localparam logic [FUNC_W-1:0] FUNC_RSVD_LO = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_RSVD_HI = 3'd7;
  localparam logic [ADDR_W-1:0] STA_ZERO = '0;
  localparam logic [ADDR_W-1:0] STA_ONES = '1;
  localparam logic [ADDR_W-1:0] STA_A    = 48'h0200_5E00_0A01;
  localparam logic [ADDR_W-1:0] STA_B    = 48'h0200_5E00_0B02;
  localparam logic [ADDR_W-1:0] STA_C    = 48'h0200_5E00_0C03;
  localparam int POOL_SIZE       = 20;
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 220;
  localparam int DRAIN_CYCLES    = TABLE_ENTRIES + 4;

  logic                  clk_i     = 1'b0;
  logic                  rst_ni    = 1'b0;
  logic                  in_valid  = 1'b0;
  logic [FUNC_W-1:0]     func      = '0;
  logic [ADDR_W-1:0]     sta_addr  = '0;
  logic [QID_W-1:0]      query_id  = '0;
  logic                  out_ready = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  wire                   in_ready;
  wire                   out_valid;
  wire                   success;
  wire [ANS_W-1:0]       answer_value;
  wire [CNT_W-1:0]       players_count;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned checked;
  int unsigned granted;
  int unsigned requests = 0;
  int unsigned settings = 0;
  bit          burst    = 1'b0;

  logic [ADDR_W-1:0] station_pool [POOL_SIZE];
  int phase_max   [PHASES] = '{16, 31, 0, 1, 16, 7, 17, 16};
  int phase_allow [PHASES] = '{1, 1, 1, 1, 0, 1, 1, 1};

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  station_association_table dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .func_i            (func),
    .station_address_i (sta_addr),
    .query_id_i        (query_id),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .success_o         (success),
    .answer_value_o    (answer_value),
    .players_count_o   (players_count),
    .cfg_we_i          (cfg_we),
    .cfg_idx_i         (cfg_idx),
    .cfg_wdata_i       (cfg_wdata)
  );

  sat_checker u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .req_valid_i       (in_valid),
    .req_ready_i       (in_ready),
    .func_i            (func),
    .station_address_i (sta_addr),
    .query_id_i        (query_id),
    .res_valid_i       (out_valid),
    .res_ready_i       (out_ready),
    .success_i         (success),
    .answer_value_i    (answer_value),
    .players_count_i   (players_count),
    .cfg_we_i          (cfg_we),
    .cfg_idx_i         (cfg_idx),
    .cfg_wdata_i       (cfg_wdata),
    .mismatch_cnt_o    (mismatches),
    .pending_cnt_o     (pending),
    .checked_cnt_o     (checked),
    .granted_cnt_o     (granted)
  );

  task automatic send_req(input logic [FUNC_W-1:0] f, input logic [ADDR_W-1:0] a,
                          input logic [QID_W-1:0] q);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    func     <= f;
    sta_addr <= a;
    query_id <= q;
    do @(posedge clk_i); while (!in_ready);
    requests++;
  endtask

  // drop valid, wait for every result, then let the block settle
  task automatic go_idle();
    in_valid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_table(input int max_clients, input int allow);
    go_idle();
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_MAX_CLIENTS;
    cfg_wdata <= CFG_DATA_W'(max_clients);
    @(posedge clk_i);
    cfg_idx   <= CFG_ALLOW_NEW;
    cfg_wdata <= CFG_DATA_W'(allow);
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    settings++;
  endtask

  // result side: random stalls, eager stretches, one long hold-off
  initial begin
    int  wait_cycles;
    int  taken;
    bit  eager;
    taken = 0;
    eager = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (taken % 32 == 0) eager = ($urandom_range(0, 3) == 0);
      wait_cycles = eager ? 0 : $urandom_range(0, 9);
      if (taken == 400) wait_cycles = 250;
      if (wait_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!(out_valid && out_ready));
      taken++;
    end
  end

  initial begin
    #5ms;
    $display("tb_top: done, errors");
    $finish;
  end

  initial begin
    logic [FUNC_W-1:0] f;
    logic [ADDR_W-1:0] a;
    logic [QID_W-1:0]  q;
    int                roll;
    int                p;
    int                n;
    station_pool[0] = STA_ZERO;
    station_pool[1] = STA_ONES;
    station_pool[2] = 48'hAAAA_AAAA_AAAA;
    station_pool[3] = 48'h5555_5555_5555;
    station_pool[4] = 48'h0000_0000_0001;
    station_pool[5] = 48'h8000_0000_0000;
    for (n = 6; n < POOL_SIZE; n++) station_pool[n] = ADDR_W'({$urandom(), $urandom()});

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: unknown stations are turned away
    send_req(FUNC_AUTH, STA_A, '0);
    send_req(FUNC_RSVD_LO, STA_ONES, '1);
    send_req(FUNC_RSVD_HI, STA_A, '1);

    // three-entry table, fill it and walk every operation
    set_table(3, 1);
    send_req(FUNC_AUTH, STA_ZERO, '0);
    send_req(FUNC_AUTH, STA_ONES, '0);
    send_req(FUNC_AUTH, STA_A, '0);
    send_req(FUNC_AUTH, STA_B, '0);
    send_req(FUNC_ASSOC, STA_ONES, '0);
    send_req(FUNC_ASSOC, STA_ONES, '0);
    send_req(FUNC_FIND_ADDR, STA_A, '0);
    send_req(FUNC_FIND_ID, STA_ZERO, 16'd2);
    send_req(FUNC_FIND_ID, STA_ZERO, 16'd0);
    send_req(FUNC_FIND_ID, STA_ONES, '1);
    send_req(FUNC_DISC, STA_ZERO, '0);
    send_req(FUNC_FIND_ADDR, STA_ZERO, '0);
    send_req(FUNC_AUTH, STA_B, '0);
    send_req(FUNC_AUTH, STA_ONES, '0);
    send_req(FUNC_ASSOC, STA_ONES, '0);
    send_req(FUNC_DISC, STA_C, '0);
    send_req(FUNC_ASSOC, STA_C, '0);
    send_req(FUNC_CLEAR, STA_ZERO, '0);
    send_req(FUNC_FIND_ID, STA_ZERO, 16'd0);

    for (p = 0; p < PHASES; p++) begin
      set_table(phase_max[p], phase_allow[p]);
      burst = (p % 3 == 1);
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < 2)       f = FUNC_CLEAR;
        else if (roll < 32) f = FUNC_AUTH;
        else if (roll < 52) f = FUNC_ASSOC;
        else if (roll < 66) f = FUNC_DISC;
        else if (roll < 80) f = FUNC_FIND_ADDR;
        else if (roll < 96) f = FUNC_FIND_ID;
        else                f = $urandom_range(0, 1) ? FUNC_RSVD_HI : FUNC_RSVD_LO;
        // mostly known stations so the table fills and empties
        if ($urandom_range(0, 99) < 85) a = station_pool[$urandom_range(0, POOL_SIZE - 1)];
        else                             a = ADDR_W'({$urandom(), $urandom()});
        if ($urandom_range(0, 99) < 80) q = QID_W'($urandom_range(0, TABLE_ENTRIES + 1));
        else                             q = QID_W'($urandom());
        send_req(f, a, q);
      end
    end
    burst = 1'b0;
    go_idle();

    $display("tb_top: %0d requests over %0d table settings", requests, settings);
    $display("tb_top: %0d results compared, %0d of them successful", checked, granted);
    if (mismatches == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
